FILE: rtl/ssci_pkg.sv
package ssci_pkg;

  localparam int PAIR_COUNT_DEF    = 23;
  localparam int CLASS_INDEX_A_DEF = 22;
  localparam int CLASS_INDEX_B_DEF = 22;

  localparam logic [31:0] INIT_MARGIN   = 32'd50;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [7:0]  THRESHOLD_RST = 8'd128;

  // Word address of the threshold register on the configuration port.
  localparam logic [0:0] CFG_THRESHOLD = 1'b0;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_UPD_A   = 3'd1,
    OP_UPD_B   = 3'd2,
    OP_DEFER_A = 3'd3,
    OP_FINAL   = 3'd4,
    OP_VERIFY  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_CRC_START,
    ST_CRC_LOAD,
    ST_CRC_BYTES,
    ST_CRC_END,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic wr;
    logic rd;
  } bank_ctl_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
  } crc_ctl_t;

endpackage

FILE: rtl/ssci_if.sv
interface ssci_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [4:0]  segment_index;
  logic [31:0] segment_value;
  logic [7:0]  generation_in;
  logic [31:0] parent_in;

  modport source (
    output valid, operation, segment_index, segment_value, generation_in, parent_in,
    input  ready
  );
  modport sink (
    input  valid, operation, segment_index, segment_value, generation_in, parent_in,
    output ready
  );
endinterface

interface ssci_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  class_code;
  logic [31:0] change_count;
  logic [31:0] stored_crc;
  logic        crc_ok;
  logic        index_rejected;

  modport source (
    output valid, class_code, change_count, stored_crc, crc_ok, index_rejected,
    input  ready
  );
  modport sink (
    input  valid, class_code, change_count, stored_crc, crc_ok, index_rejected,
    output ready
  );
endinterface

FILE: rtl/ssci_bank.sv
module ssci_bank #(
  parameter int DEPTH = ssci_pkg::PAIR_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssci_pkg::bank_ctl_t  ctl_i,
  input  logic [AW-1:0]        addr_i,
  input  logic [31:0]          wdata_i,
  output logic [31:0]          rdata_o
);
  import ssci_pkg::*;

  logic [31:0]      mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [DEPTH-1:0] valid_d;
  logic [31:0]      rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  // A clear drops every valid bit at once; a write in the same cycle wins for its entry.
  always_comb begin
    valid_d = ctl_i.clear ? '0 : valid_q;
    if (ctl_i.wr) begin
      valid_d[addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctl_i.rd) begin
        rvalid_q <= valid_q[addr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

FILE: rtl/ssci_crc.sv
module ssci_crc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssci_pkg::crc_ctl_t ctl_i,
  input  logic [31:0]        word_i,
  output logic [31:0]        crc_o
);
  import ssci_pkg::*;

  logic [31:0] shift_q;
  logic [31:0] crc_q;
  logic [31:0] crc_d;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign crc_d = crc_byte(crc_q, shift_q[7:0]);

  // The low byte is consumed each step; a load replaces the word after its last byte.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      shift_q <= word_i;
    end else if (ctl_i.step) begin
      shift_q <= {8'd0, shift_q[31:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else if (ctl_i.clear) begin
      crc_q <= '0;
    end else if (ctl_i.step) begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

FILE: rtl/segment_store_with_crc_integrity.sv
// Segment store with CRC-32 integrity.
// Items arrive on item_i (valid/ready); each gives exactly one result on result_o.
// The threshold register sits at byte address 0 of the APB port; pready is always high.
// Init, finalize, verify and an update of bank A or B that changes a segment walk
// the checksum over both banks, the generation byte and the parent id, one byte per
// cycle through a byte-serial CRC unit fed by the single read port of each bank.
// An update that changes nothing, a deferred update, a rejected index or an unknown
// operation skips the checksum walk; a valid update reads and checks its segment first.
// One item is in work at a time; item_i.ready is high only while the block is idle.
// The result lands in an output register; a new item is accepted while that result
// waits, and the next result holds in the sequencer until result_o is taken.
// Reset clears the banks (per-entry valid bits), generation, parent, count, class
// and checksum, and sets the threshold to 128. No clearing pass is needed.
module segment_store_with_crc_integrity #(
  parameter int PAIR_COUNT    = ssci_pkg::PAIR_COUNT_DEF,
  parameter int CLASS_INDEX_A = ssci_pkg::CLASS_INDEX_A_DEF,
  parameter int CLASS_INDEX_B = ssci_pkg::CLASS_INDEX_B_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ssci_item_if.sink     item_i,
  ssci_result_if.source result_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import ssci_pkg::*;

  localparam int AW = $clog2(PAIR_COUNT);
  localparam int PW = $clog2(2 * PAIR_COUNT + 3);
  localparam logic [PW-1:0] P_POS    = PW'(PAIR_COUNT);
  localparam logic [PW-1:0] GEN_POS  = PW'(2 * PAIR_COUNT);
  localparam logic [PW-1:0] PAR_POS  = PW'(2 * PAIR_COUNT + 1);
  localparam bit            CA_IN    = CLASS_INDEX_A < PAIR_COUNT;
  localparam bit            CB_IN    = CLASS_INDEX_B < PAIR_COUNT;
  localparam logic [AW-1:0] CA_ADDR  = AW'(CLASS_INDEX_A);
  localparam logic [AW-1:0] CB_ADDR  = AW'(CLASS_INDEX_B);

  state_e state_q, state_d;

  logic [2:0]  op_q;
  logic [4:0]  idx_q;
  logic [31:0] val_q;
  logic [7:0]  gen_in_q;
  logic [31:0] par_in_q;

  logic [7:0]  thr_q;
  logic [7:0]  gen_q;
  logic [31:0] par_q;
  logic [31:0] count_q;
  logic [1:0]  class_q;
  logic [31:0] crc_reg_q;
  logic [31:0] shadow_a_q;
  logic [31:0] shadow_b_q;
  logic        ok_q;
  logic        rej_q;
  logic [PW-1:0] pos_q;
  logic [1:0]  bc_q;
  logic        rd_is_b_q;

  logic        out_valid_q;
  logic [1:0]  out_class_q;
  logic [31:0] out_count_q;
  logic [31:0] out_crc_q;
  logic        out_ok_q;
  logic        out_rej_q;

  bank_ctl_t   bank_a_ctl, bank_b_ctl;
  logic [AW-1:0] addr_a, addr_b;
  logic [31:0] bank_wdata;
  logic [31:0] rdata_a, rdata_b;
  crc_ctl_t    crc_ctl;
  logic [31:0] crc_word;
  logic [31:0] crc_val;

  logic        item_accept;
  logic        cfg_write;
  logic        idx_ok;
  logic        upd_b;
  logic        recrc;
  logic        hit_a, hit_b;
  logic        changed;
  logic        last_byte;
  logic        out_free;
  logic [PW-1:0] rd_pos;
  logic [PW-1:0] ld_pos;
  logic        rd_next;
  logic [31:0] init_seg;
  logic [31:0] new_a, new_b;

  function automatic logic [AW-1:0] word_addr(logic [PW-1:0] p);
    logic [PW-1:0] t;
    t = (p < P_POS) ? p : (p - P_POS);
    return t[AW-1:0];
  endfunction

  function automatic logic [1:0] classify(logic [31:0] a, logic [31:0] b,
                                          logic [7:0] thr);
    logic a_ok, b_ok;
    a_ok = a >= {24'd0, thr};
    b_ok = b >= {24'd0, thr};
    return {~b_ok, ~a_ok};
  endfunction

  assign item_i.ready = (state_q == ST_IDLE);
  assign item_accept  = item_i.valid && item_i.ready;
  assign pready       = 1'b1;
  assign cfg_write    = psel && penable && pwrite && pready;
  assign prdata       = (paddr[2] == CFG_THRESHOLD) ? {24'd0, thr_q} : '0;

  assign idx_ok   = int'(idx_q) < PAIR_COUNT;
  assign upd_b    = (op_q == OP_UPD_B);
  assign recrc    = (op_q != OP_DEFER_A);
  assign hit_a    = !upd_b && CA_IN && (int'(idx_q) == CLASS_INDEX_A);
  assign hit_b    = upd_b && CB_IN && (int'(idx_q) == CLASS_INDEX_B);
  assign changed  = (upd_b ? rdata_b : rdata_a) != val_q;
  assign init_seg = {24'd0, thr_q} + INIT_MARGIN;
  assign new_a    = hit_a ? val_q : shadow_a_q;
  assign new_b    = hit_b ? val_q : shadow_b_q;

  // The generation word carries one byte, every other word four.
  assign last_byte = (pos_q == GEN_POS) ? (bc_q == 2'd0) : (bc_q == 2'd3);
  assign rd_pos    = (state_q == ST_CRC_START) ? '0 : pos_q + 1'b1;
  assign ld_pos    = (state_q == ST_CRC_LOAD) ? '0 : pos_q + 1'b1;
  assign rd_next   = (state_q == ST_CRC_START) ||
                     (state_q == ST_CRC_BYTES && bc_q == 2'd0 && rd_pos < GEN_POS);
  assign out_free  = !out_valid_q || result_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_accept) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (op_q)
          OP_INIT, OP_FINAL, OP_VERIFY: state_d = ST_CRC_START;
          OP_UPD_A, OP_UPD_B, OP_DEFER_A: state_d = idx_ok ? ST_CHECK : ST_DONE;
          default: state_d = ST_DONE;
        endcase
      end
      ST_CHECK: begin
        state_d = (changed && recrc) ? ST_CRC_START : ST_DONE;
      end
      ST_CRC_START: state_d = ST_CRC_LOAD;
      ST_CRC_LOAD:  state_d = ST_CRC_BYTES;
      ST_CRC_BYTES: begin
        if (last_byte && pos_q == PAR_POS) state_d = ST_CRC_END;
      end
      ST_CRC_END: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    bank_a_ctl = '0;
    bank_b_ctl = '0;
    addr_a     = word_addr(rd_pos);
    addr_b     = word_addr(rd_pos);
    bank_wdata = val_q;
    crc_ctl    = '0;
    if (ld_pos < GEN_POS) begin
      crc_word = rd_is_b_q ? rdata_b : rdata_a;
    end else if (ld_pos == GEN_POS) begin
      crc_word = {24'd0, gen_q};
    end else begin
      crc_word = par_q;
    end
    unique case (state_q)
      ST_DECODE: begin
        if (op_q == OP_INIT) begin
          bank_a_ctl.clear = 1'b1;
          bank_b_ctl.clear = 1'b1;
          bank_a_ctl.wr    = CA_IN;
          bank_b_ctl.wr    = CB_IN;
          addr_a           = CA_ADDR;
          addr_b           = CB_ADDR;
          bank_wdata       = init_seg;
        end else begin
          addr_a        = idx_q[AW-1:0];
          addr_b        = idx_q[AW-1:0];
          bank_a_ctl.rd = idx_ok && !upd_b;
          bank_b_ctl.rd = idx_ok && upd_b;
        end
      end
      ST_CHECK: begin
        addr_a        = idx_q[AW-1:0];
        addr_b        = idx_q[AW-1:0];
        bank_a_ctl.wr = changed && !upd_b;
        bank_b_ctl.wr = changed && upd_b;
      end
      ST_CRC_START: begin
        crc_ctl.clear = 1'b1;
        bank_a_ctl.rd = 1'b1;
        bank_b_ctl.rd = 1'b1;
      end
      ST_CRC_LOAD: begin
        crc_ctl.load = 1'b1;
      end
      ST_CRC_BYTES: begin
        crc_ctl.step  = 1'b1;
        crc_ctl.load  = last_byte && pos_q != PAR_POS;
        bank_a_ctl.rd = rd_next;
        bank_b_ctl.rd = rd_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (item_accept) begin
      op_q     <= item_i.operation;
      idx_q    <= item_i.segment_index;
      val_q    <= item_i.segment_value;
      gen_in_q <= item_i.generation_in;
      par_in_q <= item_i.parent_in;
    end
    if (state_q == ST_DONE && out_free) begin
      out_class_q <= class_q;
      out_count_q <= count_q;
      out_crc_q   <= crc_reg_q;
      out_ok_q    <= ok_q;
      out_rej_q   <= rej_q;
    end
    if (state_q == ST_CRC_LOAD) begin
      pos_q <= '0;
      bc_q  <= 2'd0;
    end else if (state_q == ST_CRC_BYTES) begin
      if (last_byte) begin
        pos_q <= pos_q + 1'b1;
        bc_q  <= 2'd0;
      end else begin
        bc_q <= bc_q + 2'd1;
      end
    end
    if (rd_next) begin
      rd_is_b_q <= rd_pos >= P_POS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THRESHOLD_RST;
      gen_q       <= '0;
      par_q       <= '0;
      count_q     <= '0;
      class_q     <= '0;
      crc_reg_q   <= '0;
      shadow_a_q  <= '0;
      shadow_b_q  <= '0;
      ok_q        <= 1'b0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_write && paddr[2] == CFG_THRESHOLD) begin
        thr_q <= pwdata[7:0];
      end
      if (item_accept) begin
        ok_q  <= 1'b0;
        rej_q <= 1'b0;
      end
      if (state_q == ST_DECODE) begin
        if (op_q == OP_INIT) begin
          gen_q      <= gen_in_q;
          par_q      <= par_in_q;
          count_q    <= '0;
          class_q    <= '0;
          shadow_a_q <= CA_IN ? init_seg : '0;
          shadow_b_q <= CB_IN ? init_seg : '0;
        end else if ((op_q == OP_UPD_A || op_q == OP_UPD_B || op_q == OP_DEFER_A)
                     && !idx_ok) begin
          rej_q <= 1'b1;
        end
      end
      if (state_q == ST_CHECK && changed) begin
        count_q <= count_q + 32'd1;
        if (hit_a) shadow_a_q <= val_q;
        if (hit_b) shadow_b_q <= val_q;
        if (hit_a || hit_b) class_q <= classify(new_a, new_b, thr_q);
      end
      if (state_q == ST_CRC_END) begin
        if (op_q == OP_VERIFY) begin
          ok_q <= (crc_val == crc_reg_q);
        end else begin
          crc_reg_q <= crc_val;
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.class_code     = out_class_q;
  assign result_o.change_count   = out_count_q;
  assign result_o.stored_crc     = out_crc_q;
  assign result_o.crc_ok         = out_ok_q;
  assign result_o.index_rejected = out_rej_q;

  ssci_bank #(
    .DEPTH (PAIR_COUNT),
    .AW    (AW)
  ) u_bank_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (bank_a_ctl),
    .addr_i  (addr_a),
    .wdata_i (bank_wdata),
    .rdata_o (rdata_a)
  );

  ssci_bank #(
    .DEPTH (PAIR_COUNT),
    .AW    (AW)
  ) u_bank_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (bank_b_ctl),
    .addr_i  (addr_b),
    .wdata_i (bank_wdata),
    .rdata_o (rdata_b)
  );

  ssci_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .word_i (crc_word),
    .crc_o  (crc_val)
  );

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_accept |=> state_q == ST_DECODE)
    else $error("accepted item did not enter decode");

  a_count_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DECODE && state_q != ST_CHECK) |=> $stable(count_q))
    else $error("mutation count moved outside decode or check");

  a_ok_on_verify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok_q |-> op_q == OP_VERIFY)
    else $error("checksum match flagged on a non-verify item");

  a_rej_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rej_q |-> (op_q == OP_UPD_A || op_q == OP_UPD_B || op_q == OP_DEFER_A))
    else $error("index rejection flagged on a non-update item");

  a_gen_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRC_BYTES && pos_q == GEN_POS) |-> bc_q == 2'd0)
    else $error("generation word stepped past its single byte");

endmodule
